@@ src/trv_pkg.sv @@
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types, register indexes, item kinds and the single round function
// of the Trivium keystream byte cipher.
// ----------------------------------------------------------------------------
package trv_pkg;

	// Register lengths of the three shift registers.
	localparam int LenA = 93;
	localparam int LenB = 84;
	localparam int LenC = 111;

	// Key and IV width.
	localparam int KeyW = 80;

	// Configuration register indexes (byte address is eight times the index).
	localparam logic [1:0] REG_KEY_LO = 2'd0;
	localparam logic [1:0] REG_KEY_HI = 2'd1;
	localparam logic [1:0] REG_IV_LO  = 2'd2;
	localparam logic [1:0] REG_IV_HI  = 2'd3;

	// Item kinds carried on tuser.
	localparam logic MODE_RESTART = 1'b0;
	localparam logic MODE_DATA    = 1'b1;

	// Full cipher state; bit i of each field is position i of that register.
	typedef struct packed {
		logic [LenC-1:0] c;
		logic [LenB-1:0] b;
		logic [LenA-1:0] a;
	} trv_state_t;

	// State after one round together with the keystream bit of that round.
	typedef struct packed {
		trv_state_t st;
		logic       z;
	} trv_step_t;

	// One Trivium round: output bit is taken before the AND terms.
	function automatic trv_step_t trv_round(input trv_state_t s);
		logic      t1;
		logic      t2;
		logic      t3;
		trv_step_t r;
		t1 = s.a[65] ^ s.a[92];
		t2 = s.b[68] ^ s.b[83];
		t3 = s.c[65] ^ s.c[110];
		r.z = t1 ^ t2 ^ t3;
		t1 = t1 ^ (s.a[90] & s.a[91]) ^ s.b[77];
		t2 = t2 ^ (s.b[81] & s.b[82]) ^ s.c[86];
		t3 = t3 ^ (s.c[108] & s.c[109]) ^ s.a[68];
		r.st.a = {s.a[LenA-2:0], t3};
		r.st.b = {s.b[LenB-2:0], t1};
		r.st.c = {s.c[LenC-2:0], t2};
		return r;
	endfunction

endpackage

@@ src/trv_rounds.sv @@
// ----------------------------------------------------------------------------
// trv_rounds
// Eight chained Trivium rounds. Produces the keystream byte of all eight
// rounds and the state after a selectable number of rounds (0 to 8).
// ----------------------------------------------------------------------------
module trv_rounds (
	input  trv_pkg::trv_state_t state_in,
	input  logic [3:0]          steps,     // rounds to apply, 0 to 8
	output trv_pkg::trv_state_t state_out,
	output logic [7:0]          keystream  // first round's bit in bit 7
);

	trv_pkg::trv_state_t stage [0:8];
	trv_pkg::trv_step_t  step  [0:7];

	// Round chain; the first keystream bit lands in the top bit.
	always_comb begin
		stage[0] = state_in;
		for (int k = 0; k < 8; k++) begin
			step[k]          = trv_pkg::trv_round(stage[k]);
			stage[k+1]       = step[k].st;
			keystream[7-k]   = step[k].z;
		end
	end

	// Pick the state after the requested number of rounds.
	always_comb begin
		if (steps >= 4'd8) begin
			state_out = stage[8];
		end else begin
			state_out = stage[steps[2:0]];
		end
	end

endmodule

@@ src/trivium_keystream_byte_cipher.sv @@
// ----------------------------------------------------------------------------
// trivium_keystream_byte_cipher
// Trivium stream cipher (80-bit key and IV) that enciphers one byte per item.
// ----------------------------------------------------------------------------
// Usage:
// Key and IV are written over the APB port (64-bit data, registers at byte
// addresses 0, 8, 16, 24) and take effect at the next restart request.
// The input stream carries the item kind on s_tuser (0 restart, 1 data) and
// the byte on s_tdata. A restart request gives no output; it loads key and
// IV and then runs INIT_ROUNDS warm-up rounds, eight per cycle, and holds
// off following data requests until the warm-up is done. A data request
// gives one output byte: in_byte XOR eight keystream bits. An accepted
// request passes the input register, the eight-round chain and the result
// register before m_tvalid; one request per cycle is sustained while
// m_tready is high and no warm-up runs.
// When m_tready is low the result register holds, one further request waits
// in the input register, and s_tready then drops.
// Reset clears the cipher state to all zeros, the key and IV registers, and
// both stages; data before any restart passes through unchanged.
// ----------------------------------------------------------------------------
module trivium_keystream_byte_cipher #(
	parameter int INIT_ROUNDS = 1152
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tuser,   // [0] mode
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int WarmW = (INIT_ROUNDS > 0) ? $clog2(INIT_ROUNDS + 1) : 1;

	logic [63:0] key_lo_q;
	logic [15:0] key_hi_q;
	logic [63:0] iv_lo_q;
	logic [15:0] iv_hi_q;

	logic        in_valid_s1;
	logic        in_mode_s1;
	logic [7:0]  in_byte_s1;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;

	trv_pkg::trv_state_t state_q;
	trv_pkg::trv_state_t state_next;
	trv_pkg::trv_state_t state_load;
	logic [WarmW-1:0]    warm_q;

	logic        warm_busy;
	logic        out_free;
	logic        restart_fire;
	logic        data_fire;
	logic        cfg_wr;
	logic [3:0]  warm_steps;
	logic [3:0]  steps;
	logic [7:0]  keystream;

	// Configuration write strobe and register file.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			iv_lo_q  <= '0;
			iv_hi_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				trv_pkg::REG_KEY_LO: key_lo_q <= pwdata;
				trv_pkg::REG_KEY_HI: key_hi_q <= pwdata[15:0];
				trv_pkg::REG_IV_LO:  iv_lo_q  <= pwdata;
				trv_pkg::REG_IV_HI:  iv_hi_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[4:3])
			trv_pkg::REG_KEY_LO: prdata = key_lo_q;
			trv_pkg::REG_KEY_HI: prdata = {48'd0, key_hi_q};
			trv_pkg::REG_IV_LO:  prdata = iv_lo_q;
			trv_pkg::REG_IV_HI:  prdata = {48'd0, iv_hi_q};
			default:             prdata = '0;
		endcase
	end

	// Handshake control for the input and result stages.
	assign warm_busy    = (warm_q != '0);
	assign out_free     = !out_valid_q || m_tready;
	assign restart_fire = in_valid_s1 && (in_mode_s1 == trv_pkg::MODE_RESTART);
	assign data_fire    = in_valid_s1 && (in_mode_s1 == trv_pkg::MODE_DATA) &&
	                      !warm_busy && out_free;
	assign s_tready     = !in_valid_s1 || restart_fire || data_fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_mode_s1 <= s_tuser;
			in_byte_s1 <= s_tdata;
		end
	end

	// Warm-up runs eight rounds a cycle, or the remaining rounds when fewer than eight remain.
	always_comb begin
		if (32'(warm_q) >= 8) begin
			warm_steps = 4'd8;
		end else begin
			warm_steps = 4'(warm_q);
		end
	end

	assign steps = data_fire ? 4'd8 : warm_steps;

	trv_rounds u_rounds (
		.state_in  (state_q),
		.steps     (steps),
		.state_out (state_next),
		.keystream (keystream)
	);

	// Key into the first register, IV into the second, three ones at the top
	// of the third.
	assign state_load.a = {(trv_pkg::LenA - trv_pkg::KeyW)'(0), key_hi_q, key_lo_q};
	assign state_load.b = {(trv_pkg::LenB - trv_pkg::KeyW)'(0), iv_hi_q, iv_lo_q};
	assign state_load.c = {3'b111, (trv_pkg::LenC - 3)'(0)};

	// Cipher state and warm-up counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			warm_q  <= '0;
		end else begin
			priority if (restart_fire) begin
				state_q <= state_load;
				warm_q  <= WarmW'(INIT_ROUNDS);
			end else if (data_fire) begin
				state_q <= state_next;
			end else if (warm_busy) begin
				state_q <= state_next;
				warm_q  <= warm_q - WarmW'(warm_steps);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= data_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (data_fire) begin
			out_byte_q <= in_byte_s1 ^ keystream;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;

endmodule

@@ src/trv_checker.sv @@
// ----------------------------------------------------------------------------
// trv_checker
// Port-level checks for the Trivium byte cipher, bound to the top level.
// ----------------------------------------------------------------------------
module trv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [63:0] pwdata,
	input logic [63:0] prdata,
	input logic        pready
);

	logic cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready;

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A waiting request keeps its contents until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("request changed while waiting");

	// No result shows on the first edge after reset.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// A written low key register reads back what was written while it stays addressed.
	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (paddr[4:3] == trv_pkg::REG_KEY_LO) |=>
		(paddr[4:3] != trv_pkg::REG_KEY_LO) || (prdata == $past(pwdata)))
		else $error("key register read-back mismatch");

endmodule

bind trivium_keystream_byte_cipher trv_checker u_trv_checker (.*);
